/* sv/sed_pkg.sv */
// ----------------------------------------------------------------------------
// sed_pkg
// Types and constants shared by the string escape decoder modules.
// ----------------------------------------------------------------------------
package sed_pkg;

   localparam int RSP_FIFO_DEPTH = 4;
   localparam int RSP_PTR_W      = $clog2(RSP_FIFO_DEPTH);
   localparam int RSP_CNT_W      = $clog2(RSP_FIFO_DEPTH + 1);

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_SEVEN     = 8'h37;
   localparam logic [7:0] CHAR_NINE      = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [7:0] CHAR_LOWER_B   = 8'h62;
   localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
   localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
   localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
   localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
   localparam logic [7:0] CHAR_LOWER_V   = 8'h76;
   localparam logic [7:0] CHAR_LOWER_X   = 8'h78;
   localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F   = 8'h46;

   localparam logic [7:0] BYTE_BELL      = 8'd7;
   localparam logic [7:0] BYTE_BACKSPACE = 8'd8;
   localparam logic [7:0] BYTE_TAB       = 8'd9;
   localparam logic [7:0] BYTE_NEWLINE   = 8'd10;
   localparam logic [7:0] BYTE_VTAB      = 8'd11;
   localparam logic [7:0] BYTE_FORMFEED  = 8'd12;
   localparam logic [7:0] BYTE_RETURN    = 8'd13;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_ESCAPE = 2'd1,
      MODE_OCTAL  = 2'd2,
      MODE_HEX    = 2'd3
   } decode_mode_type;

   typedef struct packed {
      logic [7:0] in_char;
      logic       last;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       end_of_literal;
      logic       bad_escape;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type word0;
      rsp_word_type word1;
   } sed_push_type;

endpackage

/* sv/sed_decode.sv */
// ----------------------------------------------------------------------------
// sed_decode
// Escape decoding state and the logic that turns one character into up to
// two result words.
// ----------------------------------------------------------------------------
module sed_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  sed_pkg::req_word_type word,
   output sed_pkg::sed_push_type push
);
   import sed_pkg::*;

   decode_mode_type mode_ff, mode_in;
   logic [8:0]      octal_ff, octal_in;
   logic [1:0]      count_ff, count_in;
   logic [3:0]      nibble_ff, nibble_in;

   rsp_word_type    slot [2];
   logic [1:0]      n;
   logic [7:0]      c;
   logic [7:0]      mapped;
   logic            is_oct;
   logic            is_hex;
   logic [3:0]      hex_d;
   logic            do_plain;

   always_comb begin
      c      = word.in_char;
      is_oct = (c >= CHAR_ZERO) && (c <= CHAR_SEVEN);
      is_hex = 1'b1;
      hex_d  = 4'd0;
      if ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) begin
         hex_d = 4'(c - CHAR_ZERO);
      end else if ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_F)) begin
         hex_d = 4'(c - CHAR_LOWER_A + 8'd10);
      end else if ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F)) begin
         hex_d = 4'(c - CHAR_UPPER_A + 8'd10);
      end else begin
         is_hex = 1'b0;
      end

      case (c)
         CHAR_LOWER_A: mapped = BYTE_BELL;
         CHAR_LOWER_B: mapped = BYTE_BACKSPACE;
         CHAR_LOWER_F: mapped = BYTE_FORMFEED;
         CHAR_LOWER_N: mapped = BYTE_NEWLINE;
         CHAR_LOWER_R: mapped = BYTE_RETURN;
         CHAR_LOWER_T: mapped = BYTE_TAB;
         CHAR_LOWER_V: mapped = BYTE_VTAB;
         default:      mapped = c;
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      octal_in  = octal_ff;
      count_in  = count_ff;
      nibble_in = nibble_ff;
      slot[0]   = '0;
      slot[1]   = '0;
      n         = 2'd0;
      do_plain  = 1'b0;

      case (mode_ff)
         MODE_NORMAL: begin
            do_plain = 1'b1;
         end
         MODE_ESCAPE: begin
            mode_in = MODE_NORMAL;
            if (is_oct) begin
               mode_in  = MODE_OCTAL;
               octal_in = 9'(c - CHAR_ZERO);
               count_in = 2'd1;
            end else if (c == CHAR_LOWER_X) begin
               mode_in   = MODE_HEX;
               count_in  = 2'd0;
               nibble_in = 4'd0;
            end else begin
               slot[0] = '{out_byte: mapped, has_byte: 1'b1, default: 1'b0};
               n       = 2'd1;
            end
         end
         MODE_OCTAL: begin
            if (is_oct && (count_ff < 2'd3)) begin
               octal_in = {octal_ff[5:0], 3'(c - CHAR_ZERO)};
               count_in = count_ff + 2'd1;
               if (count_in == 2'd3) begin
                  slot[0]   = '{out_byte: octal_in[7:0], has_byte: 1'b1, default: 1'b0};
                  n         = 2'd1;
                  octal_in  = '0;
                  count_in  = '0;
                  nibble_in = '0;
                  mode_in   = MODE_NORMAL;
               end
            end else begin
               slot[0]   = '{out_byte: octal_ff[7:0], has_byte: 1'b1, default: 1'b0};
               n         = 2'd1;
               octal_in  = '0;
               count_in  = '0;
               nibble_in = '0;
               do_plain  = 1'b1;
            end
         end
         MODE_HEX: begin
            if (is_hex) begin
               if (count_ff == 2'd0) begin
                  nibble_in = hex_d;
                  count_in  = 2'd1;
               end else begin
                  slot[0]   = '{out_byte: {nibble_ff, hex_d}, has_byte: 1'b1,
                                default: 1'b0};
                  n         = 2'd1;
                  octal_in  = '0;
                  count_in  = '0;
                  nibble_in = '0;
                  mode_in   = MODE_NORMAL;
               end
            end else begin
               if (count_ff != 2'd0) begin
                  slot[0] = '{out_byte: {4'd0, nibble_ff}, has_byte: 1'b1, default: 1'b0};
                  n       = 2'd1;
               end
               octal_in  = '0;
               count_in  = '0;
               nibble_in = '0;
               do_plain  = 1'b1;
            end
         end
         default: begin
            mode_in = MODE_NORMAL;
         end
      endcase

      if (do_plain) begin
         if (c == CHAR_BACKSLASH) begin
            mode_in = MODE_ESCAPE;
         end else begin
            mode_in = MODE_NORMAL;
            slot[n[0]] = '{out_byte: c, has_byte: 1'b1, default: 1'b0};
            n = n + 2'd1;
         end
      end

      if (word.last) begin
         if (mode_in == MODE_OCTAL) begin
            slot[n[0]] = '{out_byte: octal_in[7:0], has_byte: 1'b1, default: 1'b0};
            n = n + 2'd1;
         end else if ((mode_in == MODE_ESCAPE) || (mode_in == MODE_HEX)) begin
            slot[n[0]] = '{bad_escape: 1'b1, default: '0};
            n = n + 2'd1;
         end else if (n == 2'd0) begin
            slot[0] = '0;
            n       = 2'd1;
         end
         slot[n[0] ^ 1'b1].end_of_literal = 1'b1;
         mode_in   = MODE_NORMAL;
         octal_in  = '0;
         count_in  = '0;
         nibble_in = '0;
      end

      push.count = fire ? n : 2'd0;
      push.word0 = slot[0];
      push.word1 = slot[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NORMAL;
         octal_ff  <= '0;
         count_ff  <= '0;
         nibble_ff <= '0;
      end else if (fire) begin
         mode_ff   <= mode_in;
         octal_ff  <= octal_in;
         count_ff  <= count_in;
         nibble_ff <= nibble_in;
      end
   end

   property p_last_clears_state;
      @(posedge clock) disable iff (reset)
         (fire && word.last) |=> (mode_ff == MODE_NORMAL) && (count_ff == 2'd0);
   endproperty
   a_last_clears_state: assert property (p_last_clears_state)
      else $error("state not cleared after final character");

   property p_last_gives_result;
      @(posedge clock) disable iff (reset)
         (fire && word.last) |-> (push.count != 2'd0);
   endproperty
   a_last_gives_result: assert property (p_last_gives_result)
      else $error("final character produced no result");

   property p_bad_has_no_byte;
      @(posedge clock) disable iff (reset)
         (push.count != 2'd0 && push.word0.bad_escape) |->
            (!push.word0.has_byte && push.word0.end_of_literal);
   endproperty
   a_bad_has_no_byte: assert property (p_bad_has_no_byte)
      else $error("bad escape word carries a byte or is not final");

endmodule

/* sv/sed_rsp_fifo.sv */
// ----------------------------------------------------------------------------
// sed_rsp_fifo
// Small result buffer that takes up to two words per cycle and hands out one while rsp_stall is low.
// ----------------------------------------------------------------------------
module sed_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  sed_pkg::sed_push_type push,
   output logic                  room,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sed_pkg::rsp_word_type rsp_word
);
   import sed_pkg::*;

   rsp_word_type         mem_ff [RSP_FIFO_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 pop;
   logic [RSP_PTR_W-1:0] wr_next;

   assign rsp_valid = (count_ff != '0);
   assign rsp_word  = mem_ff[rd_ptr_ff];
   assign room      = (count_ff <= RSP_CNT_W'(RSP_FIFO_DEPTH - 2));
   assign pop       = rsp_valid && !rsp_stall;
   assign wr_next   = wr_ptr_ff + RSP_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
      count_in  = count_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.word0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.word1;
      end
   end

   property p_no_overflow;
      @(posedge clock) disable iff (reset)
         (push.count != 2'd0) |->
            ({1'b0, count_ff} + RSP_CNT_W'(push.count) <=
             (RSP_CNT_W + 1)'(RSP_FIFO_DEPTH));
   endproperty
   a_no_overflow: assert property (p_no_overflow)
      else $error("result buffer overflow");

   property p_count_bound;
      @(posedge clock) disable iff (reset)
         count_ff <= RSP_CNT_W'(RSP_FIFO_DEPTH);
   endproperty
   a_count_bound: assert property (p_count_bound)
      else $error("result buffer count out of range");

   property p_pop_moves_ptr;
      @(posedge clock) disable iff (reset)
         pop |=> (rd_ptr_ff == $past(rd_ptr_ff) + RSP_PTR_W'(1));
   endproperty
   a_pop_moves_ptr: assert property (p_pop_moves_ptr)
      else $error("read pointer did not advance on pop");

endmodule

/* sv/string_escape_decoder.sv */
// ----------------------------------------------------------------------------
// string_escape_decoder
// Decodes the body of a C-style string literal, one character per word.
// ----------------------------------------------------------------------------
// Takes character words and returns decoded byte words in order. A character
// is registered on acceptance, decoded from that register into zero, one or
// two result words once the four-word result buffer has room for two, and
// written to that buffer, from which each word is offered on the rsp_ port.
// The input side sustains one character per clock while the buffer has room,
// and the result side is drained at one word per clock while rsp_stall is
// low; since a character that yields two words needs two words drained, the
// single result port sets the rate when many characters produce two words.
// The final word of each literal carries end_of_literal, and bad_escape when
// an escape was left incomplete.
module string_escape_decoder (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sed_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sed_pkg::rsp_word_type rsp_word
);
   import sed_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;
   logic         room;
   logic         fire;
   logic         accept;
   sed_push_type push;

   assign fire      = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff <= req_word;
      end
   end

   sed_decode u_decode (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .word  (in_word_ff),
      .push  (push)
   );

   sed_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the string escape decoder.
// ----------------------------------------------------------------------------
// Character words are queued up front and driven with random gaps. Every
// accepted character is decoded by a local model into the byte words it
// should yield. Each word returned by the block is compared field by field
// against the oldest outstanding word. The result side stalls at random,
// with one long hold-off that fills the block. The sender also pauses once
// until every due word has arrived.
module testbench;
   import sed_pkg::*;

   localparam int unsigned RUN_LIMIT   = 200000;
   localparam logic [7:0]  CHAR_SQUOTE = 8'h27;
   localparam logic [7:0]  CHAR_DQUOTE = 8'h22;
   localparam logic [7:0]  CHAR_QMARK  = 8'h3F;
   localparam logic [7:0]  CHAR_LF     = 8'h0A;

   typedef logic [7:0] char_queue_type[$];

   typedef struct {
      req_word_type word;
      bit           drain_first;
   } pending_char_type;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   pending_char_type pending_chars[$];
   rsp_word_type     due_words[$];
   rsp_word_type     step_words[$];

   decode_mode_type mode_now = MODE_NORMAL;
   logic [8:0]      octal_acc = '0;
   logic [1:0]      digits_taken = '0;
   logic [3:0]      high_nibble = '0;

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned words_seen = 0;
   int unsigned send_gap = 0;
   int unsigned send_quiet = 0;
   int unsigned recv_gap = 0;
   int unsigned recv_quiet = 0;

   string_escape_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= RUN_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------- model

   function automatic void add_word(logic [7:0] value, bit has, bit bad);
      rsp_word_type w;
      w.out_byte       = has ? value : 8'h00;
      w.has_byte       = has;
      w.end_of_literal = 1'b0;
      w.bad_escape     = bad;
      if (step_words.size() < 2) step_words.insert(step_words.size(), w);
   endfunction

   function automatic int hex_digit(logic [7:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) return int'(c - CHAR_LOWER_A) + 10;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) return int'(c - CHAR_UPPER_A) + 10;
      return -1;
   endfunction

   function automatic bit is_octal(logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_SEVEN;
   endfunction

   function automatic void clear_run();
      octal_acc    = '0;
      digits_taken = '0;
      high_nibble  = '0;
   endfunction

   function automatic void plain_char(logic [7:0] c);
      if (c == CHAR_BACKSLASH) begin
         mode_now = MODE_ESCAPE;
      end else begin
         mode_now = MODE_NORMAL;
         add_word(c, 1'b1, 1'b0);
      end
   endfunction

   function automatic void escape_char(logic [7:0] c);
      logic [7:0] value;
      mode_now = MODE_NORMAL;
      if (is_octal(c)) begin
         mode_now     = MODE_OCTAL;
         octal_acc    = 9'(c - CHAR_ZERO);
         digits_taken = 2'd1;
      end else if (c == CHAR_LOWER_X) begin
         mode_now     = MODE_HEX;
         digits_taken = '0;
         high_nibble  = '0;
      end else begin
         case (c)
            CHAR_LOWER_A: value = BYTE_BELL;
            CHAR_LOWER_B: value = BYTE_BACKSPACE;
            CHAR_LOWER_F: value = BYTE_FORMFEED;
            CHAR_LOWER_N: value = BYTE_NEWLINE;
            CHAR_LOWER_R: value = BYTE_RETURN;
            CHAR_LOWER_T: value = BYTE_TAB;
            CHAR_LOWER_V: value = BYTE_VTAB;
            default:      value = c;
         endcase
         add_word(value, 1'b1, 1'b0);
      end
   endfunction

   function automatic void octal_char(logic [7:0] c);
      if (is_octal(c) && digits_taken < 2'd3) begin
         octal_acc    = 9'((octal_acc << 3) + 9'(c - CHAR_ZERO));
         digits_taken = digits_taken + 2'd1;
         if (digits_taken == 2'd3) begin
            add_word(octal_acc[7:0], 1'b1, 1'b0);
            clear_run();
            mode_now = MODE_NORMAL;
         end
      end else begin
         add_word(octal_acc[7:0], 1'b1, 1'b0);
         clear_run();
         plain_char(c);
      end
   endfunction

   function automatic void hex_char(logic [7:0] c);
      int d;
      d = hex_digit(c);
      if (d >= 0) begin
         if (digits_taken == 2'd0) begin
            high_nibble  = 4'(d);
            digits_taken = 2'd1;
         end else begin
            add_word({high_nibble, 4'(d)}, 1'b1, 1'b0);
            clear_run();
            mode_now = MODE_NORMAL;
         end
      end else begin
         if (digits_taken != 2'd0) add_word({4'h0, high_nibble}, 1'b1, 1'b0);
         clear_run();
         plain_char(c);
      end
   endfunction

   function automatic void decode_char(req_word_type w);
      step_words.delete();
      case (mode_now)
         MODE_NORMAL: plain_char(w.in_char);
         MODE_ESCAPE: escape_char(w.in_char);
         MODE_OCTAL:  octal_char(w.in_char);
         default:     hex_char(w.in_char);
      endcase
      if (w.last) begin
         if (mode_now == MODE_OCTAL) add_word(octal_acc[7:0], 1'b1, 1'b0);
         else if (mode_now == MODE_ESCAPE || mode_now == MODE_HEX) add_word(8'h00, 1'b0, 1'b1);
         else if (step_words.size() == 0) add_word(8'h00, 1'b0, 1'b0);
         step_words[step_words.size() - 1].end_of_literal = 1'b1;
         mode_now = MODE_NORMAL;
         clear_run();
      end
      foreach (step_words[i]) due_words.insert(due_words.size(), step_words[i]);
   endfunction

   // ------------------------------------------------------------ stimulus

   function automatic int unsigned pick_gap(inout int unsigned quiet);
      int unsigned r;
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         quiet = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 2);
      if (r < 96) return $urandom_range(3, 8);
      return $urandom_range(15, 40);
   endfunction

   function automatic char_queue_type text_chars(string text);
      char_queue_type chars;
      for (int i = 0; i < text.len(); i++) chars.insert(chars.size(), text[i]);
      return chars;
   endfunction

   function automatic void queue_literal(char_queue_type chars, bit drain);
      pending_char_type p;
      foreach (chars[i]) begin
         p.word.in_char = chars[i];
         p.word.last    = (i == chars.size() - 1);
         p.drain_first  = drain && (i == 0);
         pending_chars.insert(pending_chars.size(), p);
      end
   endfunction

   function automatic logic [7:0] random_hex_char();
      int unsigned d;
      d = $urandom_range(0, 15);
      if (d < 10) return CHAR_ZERO + 8'(d);
      return ($urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'(d - 10);
   endfunction

   function automatic char_queue_type random_literal();
      char_queue_type chars;
      logic [7:0]     simple[12];
      logic [7:0]     c;
      int unsigned    r;
      simple = '{CHAR_LOWER_A, CHAR_LOWER_B, CHAR_LOWER_F, CHAR_LOWER_N, CHAR_LOWER_R,
                 CHAR_LOWER_T, CHAR_LOWER_V, CHAR_SQUOTE, CHAR_DQUOTE, CHAR_QMARK,
                 CHAR_BACKSLASH, CHAR_LF};
      repeat ($urandom_range(1, 8)) begin
         r = $urandom_range(0, 99);
         if (r < 35) begin
            c = 8'($urandom_range(0, 255));
            if (c == CHAR_BACKSLASH) c = c ^ 8'h01;
            chars.insert(chars.size(), c);
         end else if (r < 50) begin
            chars.insert(chars.size(), CHAR_BACKSLASH);
            chars.insert(chars.size(), simple[$urandom_range(0, 11)]);
         end else if (r < 62) begin
            chars.insert(chars.size(), CHAR_BACKSLASH);
            repeat ($urandom_range(1, 3))
               chars.insert(chars.size(), CHAR_ZERO + 8'($urandom_range(0, 7)));
         end else if (r < 74) begin
            chars.insert(chars.size(), CHAR_BACKSLASH);
            chars.insert(chars.size(), CHAR_LOWER_X);
            chars.insert(chars.size(), random_hex_char());
            chars.insert(chars.size(), random_hex_char());
         end else if (r < 82) begin
            chars.insert(chars.size(), CHAR_BACKSLASH);
            chars.insert(chars.size(), 8'($urandom_range(0, 255)));
         end else if (r < 90) begin
            chars.insert(chars.size(), CHAR_BACKSLASH);
            chars.insert(chars.size(), CHAR_LOWER_X);
            if ($urandom_range(0, 1)) chars.insert(chars.size(), random_hex_char());
         end else begin
            chars.insert(chars.size(), 8'($urandom_range(0, 255)));
         end
      end
      return chars;
   endfunction

   initial begin
      char_queue_type extremes;
      bit             drain_done;
      extremes   = '{8'h00, 8'hFF};
      drain_done = 1'b0;
      queue_literal(extremes, 1'b0);
      queue_literal(text_chars("\\377\\18"), 1'b0);
      queue_literal(text_chars("\\9\\xaF\\x5z"), 1'b0);
      queue_literal(text_chars("\\xG"), 1'b0);
      queue_literal(text_chars("\\x4"), 1'b0);
      queue_literal(text_chars("\\"), 1'b0);
      queue_literal(text_chars("\\12"), 1'b0);
      queue_literal(text_chars("a\\\n"), 1'b0);
      while (pending_chars.size() < 430) begin
         if (!drain_done && pending_chars.size() > 220) begin
            queue_literal(random_literal(), 1'b1);
            drain_done = 1'b1;
         end else begin
            queue_literal(random_literal(), 1'b0);
         end
      end

      while (pending_chars.size() != 0 || req_valid || due_words.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

   always @(posedge clock) begin : drive_chars
      bit offer;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         offer = req_valid;
         if (req_valid && !req_stall) begin
            decode_char(req_word);
            offer    = 1'b0;
            send_gap = pick_gap(send_quiet);
         end
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_chars.size() > 0 &&
                         (!pending_chars[0].drain_first || due_words.size() == 0)) begin
               req_word <= pending_chars[0].word;
               void'(pending_chars.pop_front());
               offer = 1'b1;
            end
         end
         req_valid <= offer;
      end
   end

   // ------------------------------------------------------------- checking

   task automatic report_mismatch(string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   task automatic check_word(rsp_word_type got, rsp_word_type want);
      if (got.out_byte != want.out_byte)
         report_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
      if (got.has_byte != want.has_byte)
         report_mismatch($sformatf("has_byte %b, want %b", got.has_byte, want.has_byte));
      if (got.end_of_literal != want.end_of_literal)
         report_mismatch($sformatf("end_of_literal %b, want %b",
                                   got.end_of_literal, want.end_of_literal));
      if (got.bad_escape != want.bad_escape)
         report_mismatch($sformatf("bad_escape %b, want %b", got.bad_escape, want.bad_escape));
   endtask

   always @(posedge clock) begin : watch_words
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_words.size() == 0)
               report_mismatch($sformatf("unexpected word %h", rsp_word));
            else
               check_word(rsp_word, due_words.pop_front());
            words_seen++;
            recv_gap = (words_seen == 150) ? 80 : pick_gap(recv_quiet);
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

endmodule

/* sim.f */
sv/sed_pkg.sv
sv/sed_decode.sv
sv/sed_rsp_fifo.sv
sv/string_escape_decoder.sv
verif/testbench.sv
